### src/state_vector_pauli_xy_gate_assert.svh
// Assertion macros used by the gate engine controller.
`ifndef STATE_VECTOR_PAULI_XY_GATE_ASSERT_SVH
`define STATE_VECTOR_PAULI_XY_GATE_ASSERT_SVH

// same-cycle implication
`define SVPXY_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SVPXY_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/svpxy_pkg.sv
`default_nettype none
package svpxy_pkg;

  localparam int QUBITS = 10;
  localparam int DIM    = 1 << QUBITS;
  localparam int PAIR_W = QUBITS - 1;
  localparam int AMP_W  = 16;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_GATE  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAIR_RD,
    S_WR_LO,
    S_WR_HI,
    S_RESP
  } svpxy_state_t;

  typedef struct packed {
    logic accept;    // latch item fields
    logic wr_host;   // write amplitude from the item
    logic rd_host;   // read amplitude at item address
    logic rd_pair;   // read both amplitudes of the current pair
    logic wr_lo;     // write back lower index of pair
    logic wr_hi;     // write back upper index of pair
    logic cnt_clr;
    logic cnt_inc;
    logic out_load;
  } svpxy_cmd_t;

  typedef struct packed {
    logic noop;      // gate on incoming item changes nothing
    logic sel;       // current pair satisfies all controls
    logic last;      // pair counter at final pair
  } svpxy_sts_t;

  function automatic logic [AMP_W-1:0] neg_sat(input logic [AMP_W-1:0] v);
    logic [AMP_W-1:0] r;
    if (v == {1'b1, {(AMP_W-1){1'b0}}}) begin
      r = {1'b0, {(AMP_W-1){1'b1}}};
    end else begin
      r = ~v + AMP_W'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### src/svpxy_dpath.sv
`default_nettype none
module svpxy_dpath
  import svpxy_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,
  input  svpxy_cmd_t              cmd,
  output svpxy_sts_t              sts,
  input  wire        [1:0]        in_op,
  input  wire        [9:0]        in_addr,
  input  wire signed [15:0]       in_wr_re,
  input  wire signed [15:0]       in_wr_im,
  input  wire        [3:0]        in_target,
  input  wire        [9:0]        in_ctrl_bits,
  input  wire                     in_gate_kind,
  output logic signed [15:0]      out_rd_re,
  output logic signed [15:0]      out_rd_im,
  output logic                    out_rd_valid
);

  logic [2*AMP_W-1:0] mem [DIM];

  logic [1:0]          op_r;
  logic [QUBITS-1:0]   tmask_r;
  logic [QUBITS-1:0]   ctrl_r;
  logic                kind_r;
  logic [PAIR_W-1:0]   cnt_r;
  logic [PAIR_W-1:0]   cnt_nxt;
  logic [2*AMP_W-1:0]  rdata_a_r;
  logic [2*AMP_W-1:0]  rdata_b_r;
  logic [AMP_W-1:0]    rd_re_r;
  logic [AMP_W-1:0]    rd_im_r;
  logic                rd_valid_r;

  logic [QUBITS-1:0]   in_tmask;
  logic [QUBITS-1:0]   cnt_ext;
  logic [QUBITS-1:0]   lomask;
  logic [QUBITS-1:0]   himask;
  logic [QUBITS-1:0]   pair_lo;
  logic [QUBITS-1:0]   pair_hi;
  logic [QUBITS-1:0]   rd_addr_a;
  logic [QUBITS-1:0]   wr_addr;
  logic [2*AMP_W-1:0]  wr_data;
  logic [2*AMP_W-1:0]  new_lo;
  logic [2*AMP_W-1:0]  new_hi;
  logic [AMP_W-1:0]    a_re, a_im, b_re, b_im;

  // target >= QUBITS shifts the one out of the mask
  assign in_tmask = QUBITS'(1) << in_target;
  assign sts.noop = (in_tmask == '0) || ((in_ctrl_bits[QUBITS-1:0] & in_tmask) != '0);

  // pair index: counter with a zero bit inserted at the target position
  assign cnt_ext = {1'b0, cnt_r};
  assign lomask  = tmask_r - QUBITS'(1);
  assign himask  = ~(lomask | tmask_r);
  assign pair_lo = ((cnt_ext << 1) & himask) | (cnt_ext & lomask);
  assign pair_hi = pair_lo | tmask_r;

  assign sts.sel  = (pair_lo & ctrl_r) == ctrl_r;
  assign sts.last = &cnt_r;

  assign a_re = rdata_a_r[2*AMP_W-1:AMP_W];
  assign a_im = rdata_a_r[AMP_W-1:0];
  assign b_re = rdata_b_r[2*AMP_W-1:AMP_W];
  assign b_im = rdata_b_r[AMP_W-1:0];

  always_comb begin
    if (kind_r) begin
      // Y: lower gets b * -i, upper gets a * +i
      new_lo = {b_im, neg_sat(b_re)};
      new_hi = {neg_sat(a_im), a_re};
    end else begin
      new_lo = rdata_b_r;
      new_hi = rdata_a_r;
    end
  end

  always_comb begin
    if (cmd.wr_lo) begin
      wr_addr = pair_lo;
      wr_data = new_lo;
    end else if (cmd.wr_hi) begin
      wr_addr = pair_hi;
      wr_data = new_hi;
    end else begin
      wr_addr = in_addr[QUBITS-1:0];
      wr_data = {in_wr_re, in_wr_im};
    end
  end

  assign rd_addr_a = cmd.rd_pair ? pair_lo : in_addr[QUBITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_host || cmd.wr_lo || cmd.wr_hi) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_host || cmd.rd_pair) begin
      rdata_a_r <= mem[rd_addr_a];
    end
    if (cmd.rd_pair) begin
      rdata_b_r <= mem[pair_hi];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= in_op;
      tmask_r <= in_tmask;
      ctrl_r  <= in_ctrl_bits[QUBITS-1:0];
      kind_r  <= in_gate_kind;
    end
    if (cmd.out_load) begin
      if (op_r == OP_READ) begin
        rd_re_r    <= a_re;
        rd_im_r    <= a_im;
        rd_valid_r <= 1'b1;
      end else begin
        rd_re_r    <= '0;
        rd_im_r    <= '0;
        rd_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + PAIR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign out_rd_re    = rd_re_r;
  assign out_rd_im    = rd_im_r;
  assign out_rd_valid = rd_valid_r;

endmodule
`default_nettype wire

### src/svpxy_ctrl.sv
`default_nettype none
`include "state_vector_pauli_xy_gate_assert.svh"
module svpxy_ctrl
  import svpxy_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_op,
  output logic        out_valid,
  input  wire         out_stall,
  output svpxy_cmd_t  cmd,
  input  svpxy_sts_t  sts
);

  svpxy_state_t state_r, state_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         in_acc;
  logic         out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_GATE && !sts.noop) begin
            state_nxt = S_PAIR_RD;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_PAIR_RD: begin
        if (sts.sel) begin
          state_nxt = S_WR_LO;
        end else if (sts.last) begin
          state_nxt = S_RESP;
        end
      end
      S_WR_LO: state_nxt = S_WR_HI;
      S_WR_HI: state_nxt = sts.last ? S_RESP : S_PAIR_RD;
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.accept  = in_acc;
        cmd.wr_host = in_acc && (in_op == OP_WRITE);
        cmd.rd_host = in_acc && (in_op == OP_READ);
        cmd.cnt_clr = in_acc;
      end
      S_PAIR_RD: begin
        cmd.rd_pair = sts.sel;
        cmd.cnt_inc = !sts.sel;
      end
      S_WR_LO: cmd.wr_lo = 1'b1;
      S_WR_HI: begin
        cmd.wr_hi   = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      S_RESP: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `SVPXY_ASSERT_NXT(a_acc_leaves_idle, in_acc, state_r != S_IDLE, "accepted item left idle")
  `SVPXY_ASSERT_NXT(a_lo_then_hi, state_r == S_WR_LO, state_r == S_WR_HI, "pair write split")
  `SVPXY_ASSERT_NXT(a_last_pair_done, cmd.cnt_inc && sts.last, state_r == S_RESP,
                    "gate did not finish after last pair")
  `SVPXY_ASSERT_NXT(a_result_kept, out_valid_r && out_stall, out_valid_r,
                    "stalled result dropped")

endmodule
`default_nettype wire

### src/state_vector_pauli_xy_gate.sv
`default_nettype none
// Controlled Pauli X/Y gate engine on a 1024-entry state vector of Q1.15 complex
// amplitudes. Each item writes one amplitude (op 0), reads one (op 1) or applies
// a gate (op 2); every item yields exactly one result, carrying data only for a
// read. A gate walks all 512 index pairs of its target bit: a pair that fails the
// controls is skipped, and a pair that is swapped takes one dual read, then one
// write per amplitude on the single write port. A gate whose target is out of
// range or among its controls goes straight to its result. Amplitudes are
// undefined until written. The next item is taken as soon as a result is in the
// output register.
module state_vector_pauli_xy_gate
  import svpxy_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire         [1:0]  in_op,
  input  wire         [9:0]  in_addr,
  input  wire signed  [15:0] in_wr_re,
  input  wire signed  [15:0] in_wr_im,
  input  wire         [3:0]  in_target,
  input  wire         [9:0]  in_ctrl_bits,
  input  wire                in_gate_kind,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [15:0] out_rd_re,
  output logic signed [15:0] out_rd_im,
  output logic               out_rd_valid
);

  svpxy_cmd_t cmd;
  svpxy_sts_t sts;

  svpxy_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  svpxy_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_op        (in_op),
    .in_addr      (in_addr),
    .in_wr_re     (in_wr_re),
    .in_wr_im     (in_wr_im),
    .in_target    (in_target),
    .in_ctrl_bits (in_ctrl_bits),
    .in_gate_kind (in_gate_kind),
    .out_rd_re    (out_rd_re),
    .out_rd_im    (out_rd_im),
    .out_rd_valid (out_rd_valid)
  );

endmodule
`default_nettype wire

### sim/state_vector_pauli_xy_gate_checker.sv
module state_vector_pauli_xy_gate_checker
  import svpxy_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_stall,
  input  wire        [1:0]  in_op,
  input  wire        [9:0]  in_addr,
  input  wire signed [15:0] in_wr_re,
  input  wire signed [15:0] in_wr_im,
  input  wire        [3:0]  in_target,
  input  wire        [9:0]  in_ctrl_bits,
  input  wire               in_gate_kind,
  input  wire               out_valid,
  input  wire               out_stall,
  input  wire signed [15:0] out_rd_re,
  input  wire signed [15:0] out_rd_im,
  input  wire               out_rd_valid,
  output int unsigned       mismatches,
  output int unsigned       outstanding
);

  typedef struct packed {
    logic signed [AMP_W-1:0] re;
    logic signed [AMP_W-1:0] im;
    logic                    vld;
  } amp_reading_t;

  amp_reading_t            readings_due[$];
  logic signed [AMP_W-1:0] sv_re [DIM];
  logic signed [AMP_W-1:0] sv_im [DIM];
  int unsigned             res_no;

  function automatic logic signed [AMP_W-1:0] negate_clamped(input logic signed [AMP_W-1:0] v);
    logic signed [AMP_W-1:0] r;
    if (v == {1'b1, {(AMP_W-1){1'b0}}}) begin
      r = {1'b0, {(AMP_W-1){1'b1}}};
    end else begin
      r = -v;
    end
    return r;
  endfunction

  // swap every pair across the target bit whose index has all controls set
  function automatic void apply_controlled_pauli(input logic [3:0] tq, input logic [9:0] ctl,
                                                 input logic is_y);
    logic [QUBITS-1:0]       tmask;
    logic [QUBITS-1:0]       cmask;
    logic [QUBITS-1:0]       lo;
    logic [QUBITS-1:0]       hi;
    logic signed [AMP_W-1:0] ar, ai, br, bi;
    if (int'(tq) >= QUBITS) return;
    tmask = QUBITS'(1) << tq;
    cmask = QUBITS'(ctl);
    if ((cmask & tmask) != '0) return;
    for (int i = 0; i < DIM; i++) begin
      lo = QUBITS'(i);
      if ((lo & tmask) != '0 || (lo & cmask) != cmask) continue;
      hi = lo | tmask;
      ar = sv_re[lo];
      ai = sv_im[lo];
      br = sv_re[hi];
      bi = sv_im[hi];
      if (is_y) begin
        // lower gets b * -i, upper gets a * +i
        sv_re[lo] = bi;
        sv_im[lo] = negate_clamped(br);
        sv_re[hi] = negate_clamped(ai);
        sv_im[hi] = ar;
      end else begin
        sv_re[lo] = br;
        sv_im[lo] = bi;
        sv_re[hi] = ar;
        sv_im[hi] = ai;
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    if (mismatches < 40) begin
      $display("[%0t] result %0d: %s got %0d, expected %0d", $time, res_no, what, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    amp_reading_t want;
    amp_reading_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = '0;
        case (in_op)
          OP_WRITE: begin
            sv_re[QUBITS'(in_addr)] = in_wr_re;
            sv_im[QUBITS'(in_addr)] = in_wr_im;
          end
          OP_READ: begin
            want.re  = sv_re[QUBITS'(in_addr)];
            want.im  = sv_im[QUBITS'(in_addr)];
            want.vld = 1'b1;
          end
          OP_GATE: apply_controlled_pauli(in_target, in_ctrl_bits, in_gate_kind);
          default: ;
        endcase
        readings_due.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = '{re: out_rd_re, im: out_rd_im, vld: out_rd_valid};
        if (readings_due.size() == 0) begin
          report_mismatch("unexpected item, rd_valid", 32'(got.vld), 0);
        end else begin
          want = readings_due.pop_front();
          if (got.re !== want.re) report_mismatch("rd_re", 32'(got.re), 32'(want.re));
          if (got.im !== want.im) report_mismatch("rd_im", 32'(got.im), 32'(want.im));
          if (got.vld !== want.vld) begin
            report_mismatch("rd_valid", 32'(got.vld), 32'(want.vld));
          end
        end
        res_no++;
      end
      outstanding <= readings_due.size();
    end
  end

endmodule

### sim/testbench.sv
module testbench;
  import svpxy_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic       KIND_X   = 1'b0;
  localparam logic       KIND_Y   = 1'b1;
  // upper quarter of the vector: the only entries written, read or touched by a gate
  localparam logic [9:0] REGION   = 10'h300;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic        [1:0]  in_op = '0;
  logic        [9:0]  in_addr = '0;
  logic signed [15:0] in_wr_re = '0;
  logic signed [15:0] in_wr_im = '0;
  logic        [3:0]  in_target = '0;
  logic        [9:0]  in_ctrl_bits = '0;
  logic               in_gate_kind = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_rd_re;
  logic signed [15:0] out_rd_im;
  logic               out_rd_valid;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned rcv_cnt = 0;
  logic        calm = 1'b0;

  state_vector_pauli_xy_gate dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_addr      (in_addr),
    .in_wr_re     (in_wr_re),
    .in_wr_im     (in_wr_im),
    .in_target    (in_target),
    .in_ctrl_bits (in_ctrl_bits),
    .in_gate_kind (in_gate_kind),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rd_re    (out_rd_re),
    .out_rd_im    (out_rd_im),
    .out_rd_valid (out_rd_valid)
  );

  state_vector_pauli_xy_gate_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_addr      (in_addr),
    .in_wr_re     (in_wr_re),
    .in_wr_im     (in_wr_im),
    .in_target    (in_target),
    .in_ctrl_bits (in_ctrl_bits),
    .in_gate_kind (in_gate_kind),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rd_re    (out_rd_re),
    .out_rd_im    (out_rd_im),
    .out_rd_valid (out_rd_valid),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("** state_vector_pauli_xy_gate: FAILED **");
    $finish;
  end

  function automatic logic signed [15:0] pick_amp();
    logic signed [15:0] v;
    case ($urandom_range(0, 7))
      0:       v = 16'sh8000;
      1:       v = 16'sh7FFF;
      2:       v = 16'sh0000;
      3:       v = -16'sd1;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic offer(input logic [1:0] op, input logic [9:0] addr,
                       input logic signed [15:0] re, input logic signed [15:0] im,
                       input logic [3:0] tgt, input logic [9:0] ctl, input logic kind);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_addr      <= addr;
    in_wr_re     <= re;
    in_wr_im     <= im;
    in_target    <= tgt;
    in_ctrl_bits <= ctl;
    in_gate_kind <= kind;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // unused fields carry random bits
  task automatic put_amp(input logic [9:0] addr, input logic signed [15:0] re,
                         input logic signed [15:0] im);
    offer(OP_WRITE, addr, re, im, 4'($urandom), 10'($urandom), 1'($urandom));
  endtask

  task automatic get_amp(input logic [9:0] addr);
    offer(OP_READ, addr, 16'($urandom), 16'($urandom), 4'($urandom), 10'($urandom),
          1'($urandom));
  endtask

  task automatic run_gate(input logic [3:0] tgt, input logic [9:0] ctl, input logic kind);
    offer(OP_GATE, 10'($urandom), 16'($urandom), 16'($urandom), tgt, ctl, kind);
  endtask

  // result side; two long hold-offs let the block back up into its input
  initial begin
    int hold;
    wait (rst_n === 1'b1);
    forever begin
      if (rcv_cnt == 150 || rcv_cnt == 420) begin
        hold = 300;
      end else begin
        hold = calm ? 0 : $urandom_range(0, 9);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      rcv_cnt++;
    end
  end

  initial begin
    int          sel;
    int unsigned waited;
    logic [3:0]  tgt;
    logic [9:0]  ctl;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // fill the upper quarter; every gate that changes anything keeps both top bits among its controls
    for (int a = 0; a < 256; a++) begin
      if (a % 128 == 0) calm = ($urandom_range(0, 3) == 0);
      put_amp(REGION | 10'(a), pick_amp(), pick_amp());
    end
    calm = 1'b0;

    get_amp(10'd768);
    get_amp(10'd1023);
    put_amp(10'd768, 16'sh8000, 16'sh8000);
    put_amp(10'd769, 16'sh7FFF, 16'sh8000);
    put_amp(10'd1023, 16'sh7FFF, 16'sh7FFF);
    run_gate(4'd0, 10'h300, KIND_X);
    get_amp(10'd768);
    get_amp(10'd769);
    // Y on the most negative values: negation must clamp
    run_gate(4'd0, 10'h300, KIND_Y);
    get_amp(10'd768);
    get_amp(10'd769);
    run_gate(4'd7, 10'h37F, KIND_Y);
    get_amp(10'd895);
    get_amp(10'd1023);
    run_gate(4'd9, 10'h200, KIND_X);   // target listed as a control
    run_gate(4'd10, 10'h000, KIND_X);  // target past the top qubit
    run_gate(4'd15, 10'h3FF, KIND_Y);
    offer(OP_SPARE, 10'($urandom), 16'($urandom), 16'($urandom), 4'($urandom),
          10'($urandom), 1'($urandom));
    get_amp(10'd1023);
    run_gate(4'd3, 10'h3F7, KIND_X);
    get_amp(10'd1015);
    get_amp(10'd1023);

    for (int n = 0; n < 300; n++) begin
      if (n % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 38) begin
        put_amp(REGION | 10'($urandom_range(0, 255)), pick_amp(), pick_amp());
      end else if (sel < 73) begin
        get_amp(REGION | 10'($urandom_range(0, 255)));
      end else if (sel < 95) begin
        tgt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15))
                                          : 4'($urandom_range(0, 9));
        // mostly sparse control sets so a fair share of pairs get swapped
        case ($urandom_range(0, 3))
          0:       ctl = 10'($urandom);
          1:       ctl = '0;
          default: ctl = 10'($urandom & $urandom & $urandom);
        endcase
        run_gate(tgt, ctl | REGION, 1'($urandom));
      end else begin
        offer(OP_SPARE, 10'($urandom), 16'($urandom), 16'($urandom), 4'($urandom),
              10'($urandom), 1'($urandom));
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (outstanding != 0 && waited < 4000);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("** state_vector_pauli_xy_gate: PASSED **");
    end else begin
      $display("** state_vector_pauli_xy_gate: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/svpxy_pkg.sv
src/svpxy_dpath.sv
src/svpxy_ctrl.sv
src/state_vector_pauli_xy_gate.sv
sim/state_vector_pauli_xy_gate_checker.sv
sim/testbench.sv
